[rtl/integer_to_radix_digits_unit_defines.svh]
// Assertion macros used by the checker file of the radix digit unit.
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITDR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itdr assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ITDR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itdr assertion failed");

`endif

[rtl/itdr_pkg.sv]
// Types, constants and helpers shared by the radix digit unit.
`default_nettype none
package itdr_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_SYMBOLS    = 16;
	localparam int ALPHA_SLOTS    = 16;
	localparam int MIN_RADIX      = 2;
	localparam int STEP_BITS      = 8;
	localparam int DIGIT_W        = 4;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;

	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 64;
	localparam logic [REG_IDX_W-1:0] REG_DIGIT_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	typedef struct packed {
		logic [4:0]  digit_count;
		logic [63:0] symbols_high;
		logic [63:0] symbols_low;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

	function automatic logic [7:0] sym_at(input cfg_t c, input logic [DIGIT_W-1:0] idx);
		logic [127:0] all;
		all = {c.symbols_high, c.symbols_low};
		return all[{idx, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

[rtl/itdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itdr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/itdr_front.sv]
// Front end: accepts values, checks the alphabet, forms sign and magnitude.
`default_nettype none
module itdr_front import itdr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  start,
	input  wire logic                  full,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire cfg_t                  cfg,
	output logic                       push,
	output logic      [VALUE_BITS:0]   item
);

	logic       alpha_ok;
	logic       neg;
	logic [7:0] sym [ALPHA_SLOTS];

	always_comb begin
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			sym[i] = sym_at(cfg, DIGIT_W'(i));
		end
	end

	always_comb begin
		alpha_ok = (cfg.digit_count >= 5'(MIN_RADIX)) && (cfg.digit_count <= 5'(MAX_SYMBOLS))
			&& (cfg.digit_count <= 5'(ALPHA_SLOTS));
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			if (5'(i) < cfg.digit_count) begin
				if (sym[i] == 8'h00 || sym[i] == SYM_PLUS || sym[i] == SYM_MINUS) begin
					alpha_ok = 1'b0;
				end
				for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
					if (5'(j) < cfg.digit_count && sym[j] == sym[i]) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

	assign neg  = value[VALUE_BITS-1];
	// Magnitude as unsigned, so the most negative value fits.
	assign item = {neg, neg ? (~value + 1'b1) : value};
	// Drop the transfer silently when the alphabet is bad.
	assign push = start && !full && alpha_ok;

endmodule
`default_nettype wire

[rtl/itdr_queue.sv]
// Two-entry queue between the front end and the conversion engine.
`default_nettype none
module itdr_queue #(
	parameter int WIDTH = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic                  full
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

[rtl/itdr_back.sv]
// Conversion engine: repeated division by the radix, then digit readout.
`default_nettype none
module itdr_back import itdr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                item_valid,
	input  wire logic [VALUE_BITS:0] item,
	output logic                     pop,
	output logic                     strobe,
	output logic      [7:0]          symbol,
	output logic                     last
);

	localparam int PAD_BITS = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int STEPS    = PAD_BITS / STEP_BITS;
	localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CNT_W    = $clog2(VALUE_BITS + 1);
	localparam int ADDR_W   = $clog2(VALUE_BITS);

	back_state_t state_q, state_d;

	logic [PAD_BITS-1:0]  work_q, work_d;
	logic [DIGIT_W-1:0]   rem_q, rem_d;
	logic [STEP_BITS-1:0] qbyte;
	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     cnt_q, cnt_m1;
	logic                 last_step;
	logic                 div_en, ram_we, ram_re, emit_sign, emit_last;
	logic [DIGIT_W-1:0]   rd_data;
	logic                 pend_s1, sign_s1, last_s1;
	logic                 strobe_q, last_q;
	logic [7:0]           symbol_q;

	// Eight restoring steps of the long division per cycle while dividing.
	always_comb begin
		logic [DIGIT_W:0] r5;
		rem_d = rem_q;
		for (int b = 0; b < STEP_BITS; b++) begin
			r5 = {rem_d, work_q[PAD_BITS-1-b]};
			if (r5 >= cfg.digit_count) begin
				r5 = r5 - cfg.digit_count;
				qbyte[STEP_BITS-1-b] = 1'b1;
			end else begin
				qbyte[STEP_BITS-1-b] = 1'b0;
			end
			rem_d = r5[DIGIT_W-1:0];
		end
		work_d = (work_q << STEP_BITS) | PAD_BITS'(qbyte);
	end

	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign cnt_m1    = cnt_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_en    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		emit_sign = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					pop       = 1'b1;
					emit_sign = item[VALUE_BITS];
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				div_en = 1'b1;
				if (last_step) begin
					ram_we = 1'b1;
					if (work_d == '0) begin
						state_d = BK_OUT;
					end
				end
			end
			BK_OUT: begin
				ram_re    = 1'b1;
				emit_last = (cnt_q == CNT_W'(1));
				if (cnt_q == CNT_W'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= '0;
				cnt_q  <= '0;
			end else if (div_en) begin
				if (last_step) begin
					step_q <= '0;
					cnt_q  <= cnt_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end else if (ram_re) begin
				cnt_q <= cnt_m1;
			end
			pend_s1  <= emit_sign || ram_re;
			strobe_q <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= PAD_BITS'(item[VALUE_BITS-1:0]);
			rem_q  <= '0;
		end else if (div_en) begin
			work_q <= work_d;
			rem_q  <= last_step ? '0 : rem_d;
		end
		sign_s1  <= emit_sign;
		last_s1  <= emit_last;
		symbol_q <= sign_s1 ? SYM_MINUS : sym_at(cfg, rd_data);
		last_q   <= last_s1;
	end

	itdr_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_digit_buffer (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(rem_d),
		.re   (ram_re),
		.raddr(cnt_m1[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	assign strobe = strobe_q;
	assign symbol = symbol_q;
	assign last   = last_q;

endmodule
`default_nettype wire

[rtl/integer_to_radix_digits_unit.sv]
// Top level of the integer to radix digit string unit.
// Converts a signed VALUE_BITS-bit integer into characters of the configured
// alphabet, '-' first for negative values, most significant digit first, with
// last set on the final character. A value is taken when start is high and
// busy is low; busy rises only when the two-entry input queue is full. With an
// invalid alphabet the value is taken and yields nothing. Digits of a value come
// one per cycle on strobe and cannot be held off. Per value the engine fetches
// it from the queue, divides it by the radix once per digit (eight quotient
// bits a cycle) and writes each remainder to the digit RAM, then reads the
// digits back through the registered output. Configuration takes effect at once.
`default_nettype none
module integer_to_radix_digits_unit import itdr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data,
	output logic                       strobe,
	output logic      [7:0]            symbol,
	output logic                       last
);

	cfg_t              cfg_q;
	logic              push, pop, empty, full;
	logic [VALUE_BITS:0] front_item, back_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DIGIT_COUNT:  cfg_q.digit_count  <= wr_data[4:0];
				REG_SYMBOLS_LOW:  cfg_q.symbols_low  <= wr_data;
				REG_SYMBOLS_HIGH: cfg_q.symbols_high <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = full;

	itdr_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.start(start),
		.full (full),
		.value(value),
		.cfg  (cfg_q),
		.push (push),
		.item (front_item)
	);

	itdr_queue #(
		.WIDTH(VALUE_BITS + 1)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_item),
		.pop   (pop),
		.rdata (back_item),
		.empty (empty),
		.full  (full)
	);

	itdr_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(!empty),
		.item      (back_item),
		.pop       (pop),
		.strobe    (strobe),
		.symbol    (symbol),
		.last      (last)
	);

endmodule
`default_nettype wire

[rtl/itdr_checker.sv]
// Port-level checks on the output stream of the radix digit unit.
`default_nettype none
`include "integer_to_radix_digits_unit_defines.svh"
module itdr_checker import itdr_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       strobe,
	input wire logic [7:0] symbol,
	input wire logic       last
);

	// A valid alphabet never holds a zero byte or a plus sign.
	`ITDR_ASSERT_IMP(a_sym_nonzero, strobe, symbol != 8'h00)
	`ITDR_ASSERT_IMP(a_sym_not_plus, strobe, symbol != SYM_PLUS)
	// The sign always has digits after it.
	`ITDR_ASSERT_IMP(a_sign_not_last, strobe && symbol == SYM_MINUS, !last)
	// Digits need the divider, so a gap follows the sign.
	`ITDR_ASSERT_NXT(a_gap_after_sign, strobe && symbol == SYM_MINUS, !strobe)

endmodule

bind integer_to_radix_digits_unit itdr_checker u_itdr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.strobe(strobe),
	.symbol(symbol),
	.last  (last)
);
`default_nettype wire

[verif/radix_string_checker.sv]
`timescale 1ns / 1ps
// Checker for the radix digit unit: tracks the alphabet, predicts characters, compares them.
module radix_string_checker
	import itdr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [VALUE_BITS_DEF-1:0] value,
	input  logic                      wr_en,
	input  logic [REG_IDX_W-1:0]      wr_index,
	input  logic [REG_DATA_W-1:0]     wr_data,
	input  logic                      strobe,
	input  logic [7:0]                symbol,
	input  logic                      last,
	output int                        pending,
	output int                        error_count,
	output int                        checked
);

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} char_t;

	logic [4:0]  radix_reg;
	logic [63:0] glyphs_low;
	logic [63:0] glyphs_high;
	char_t       expected_chars[$];
	char_t       oldest;

	function automatic logic [7:0] glyph(input int idx);
		logic [127:0] glyph_bits;
		glyph_bits = {glyphs_high, glyphs_low};
		// slots past the table read as a zero byte
		return (idx < ALPHA_SLOTS) ? glyph_bits[idx*8 +: 8] : 8'h00;
	endfunction

	function automatic bit alphabet_usable();
		logic [7:0] g;
		if (radix_reg < MIN_RADIX || radix_reg > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < radix_reg; i++) begin
			g = glyph(i);
			if (g == 8'h00 || g == SYM_PLUS || g == SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < radix_reg; j++)
				if (glyph(j) == g)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queue the characters that one transfer of a value must produce.
	function automatic void spell_value(input logic [VALUE_BITS_DEF-1:0] v);
		logic [VALUE_BITS_DEF-1:0] mag;
		logic [VALUE_BITS_DEF-1:0] base;
		logic [DIGIT_W-1:0]        digits [VALUE_BITS_DEF];
		int                        n;
		if (!alphabet_usable())
			return;
		base = VALUE_BITS_DEF'(radix_reg);
		// unsigned negate keeps the most negative value intact
		mag = v[VALUE_BITS_DEF-1] ? -v : v;
		n = 0;
		do begin
			digits[n] = DIGIT_W'(mag % base);
			n++;
			mag = mag / base;
		end while (mag != 0);
		if (v[VALUE_BITS_DEF-1])
			expected_chars.push_back('{symbol: SYM_MINUS, last: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			expected_chars.push_back('{symbol: glyph(digits[k]), last: (k == 0)});
	endfunction

	function automatic void flag(input string what, input logic [7:0] want, input logic [7:0] got);
		error_count++;
		$error("%s mismatch: expected %h, actual %h", what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_reg   <= '0;
			glyphs_low  <= '0;
			glyphs_high <= '0;
			expected_chars.delete();
			pending     <= 0;
			error_count = 0;
			checked     = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_DIGIT_COUNT:  radix_reg   <= wr_data[4:0];
					REG_SYMBOLS_LOW:  glyphs_low  <= wr_data;
					REG_SYMBOLS_HIGH: glyphs_high <= wr_data;
					default: ;
				endcase
			end
			if (strobe) begin
				checked++;
				if (expected_chars.size() == 0) begin
					error_count++;
					$error("unexpected character: symbol %h, last %b", symbol, last);
				end else begin
					oldest = expected_chars.pop_front();
					if (symbol !== oldest.symbol)
						flag("symbol", oldest.symbol, symbol);
					if (last !== oldest.last)
						flag("last", {7'd0, oldest.last}, {7'd0, last});
				end
			end
			if (start && !busy)
				spell_value(value);
			pending <= expected_chars.size();
		end
	end

endmodule

[verif/tb_integer_to_radix_digits_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the radix digit unit: clock, reset, stimulus and verdict.
module tb_integer_to_radix_digits_unit;
	import itdr_pkg::*;

	localparam int DRAIN_CYCLES  = 200;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_TARGET = 440;
	localparam int PHASE_ITEMS   = 40;

	typedef enum int {
		FLAW_NONE,
		FLAW_DUP,
		FLAW_PLUS,
		FLAW_MINUS,
		FLAW_ZERO,
		FLAW_FEW,
		FLAW_MANY
	} flaw_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [VALUE_BITS_DEF-1:0] value;
	logic                      wr_en;
	logic [REG_IDX_W-1:0]      wr_index;
	logic [REG_DATA_W-1:0]     wr_data;
	logic                      strobe;
	logic [7:0]                symbol;
	logic                      last;
	int                        pending;
	int                        error_count;
	int                        checked;

	int values_sent;
	int alphabets_loaded;
	int random_good;
	int random_ignored;

	logic [VALUE_BITS_DEF-1:0] corner_values [4] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
	};
	logic [VALUE_BITS_DEF-1:0] decimal_values [8] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7FFF_FFFF, 32'h8000_0000
	};

	integer_to_radix_digits_unit #(
		.VALUE_BITS(VALUE_BITS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.strobe   (strobe),
		.symbol   (symbol),
		.last     (last)
	);

	radix_string_checker char_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.strobe      (strobe),
		.symbol      (symbol),
		.last        (last),
		.pending     (pending),
		.error_count (error_count),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$error("run timed out");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// Build an alphabet of distinct legal symbols, then break it as asked.
	task automatic load_alphabet(input int radix, input flaw_t flaw);
		logic [7:0]   glyphs [ALPHA_SLOTS];
		logic [255:0] taken;
		logic [127:0] glyph_bits;
		logic [63:0]  count_word;
		int           count;
		int           slot;
		taken = '0;
		taken[8'h00] = 1'b1;
		taken[SYM_PLUS] = 1'b1;
		taken[SYM_MINUS] = 1'b1;
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			if (i < radix) begin
				do glyphs[i] = 8'($urandom_range(1, 255)); while (taken[glyphs[i]]);
				taken[glyphs[i]] = 1'b1;
			end else begin
				glyphs[i] = 8'($urandom_range(0, 255));
			end
		end
		count = radix;
		slot = $urandom_range(0, radix - 1);
		case (flaw)
			FLAW_DUP:   glyphs[slot] = glyphs[(slot + 1) % radix];
			FLAW_PLUS:  glyphs[slot] = SYM_PLUS;
			FLAW_MINUS: glyphs[slot] = SYM_MINUS;
			FLAW_ZERO:  glyphs[slot] = 8'h00;
			FLAW_FEW:   count = $urandom_range(0, MIN_RADIX - 1);
			FLAW_MANY:  count = $urandom_range(MAX_SYMBOLS + 1, 31);
			default: ;
		endcase
		for (int i = 0; i < ALPHA_SLOTS; i++)
			glyph_bits[i*8 +: 8] = glyphs[i];
		// upper bits of the count word are don't-care
		count_word = {$urandom, $urandom};
		count_word[4:0] = 5'(count);
		write_reg(REG_SYMBOLS_LOW, glyph_bits[63:0]);
		write_reg(REG_SYMBOLS_HIGH, glyph_bits[127:64]);
		write_reg(REG_DIGIT_COUNT, count_word);
		wr_en <= 1'b0;
		alphabets_loaded++;
	endtask

	task automatic send_value(input logic [VALUE_BITS_DEF-1:0] v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		values_sent++;
	endtask

	// Hold off until every predicted character has come out, or the wait limit runs out.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		for (int w = 0; pending != 0 && w < DRAIN_LIMIT; w++)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VALUE_BITS_DEF-1:0] draw_value();
		case ($urandom_range(0, 5))
			0:       return VALUE_BITS_DEF'($urandom_range(0, 300));
			1:       return -VALUE_BITS_DEF'($urandom_range(1, 300));
			2:       return corner_values[$urandom_range(0, 3)];
			default: return $urandom;
		endcase
	endfunction

	initial begin
		flaw_t flaw;
		int    radix;
		int    phase;
		bit    steady;
		bit    drained_once;
		arst_n   = 1'b0;
		start    = 1'b0;
		value    = '0;
		wr_en    = 1'b0;
		wr_index = REG_DIGIT_COUNT;
		wr_data  = '0;
		values_sent = 0;
		alphabets_loaded = 0;
		random_good = 0;
		random_ignored = 0;
		drained_once = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty alphabet out of reset: value is taken, nothing comes out
		send_value(32'd12345, 0);
		settle();

		load_alphabet(10, FLAW_NONE);
		foreach (decimal_values[i])
			send_value(decimal_values[i], $urandom_range(0, 4));
		settle();
		load_alphabet(MIN_RADIX, FLAW_NONE);
		foreach (corner_values[i])
			send_value(corner_values[i], $urandom_range(0, 4));
		settle();
		load_alphabet(MAX_SYMBOLS, FLAW_NONE);
		foreach (corner_values[i])
			send_value(corner_values[i], 0);
		settle();
		for (int f = FLAW_DUP; f <= FLAW_MANY; f++) begin
			load_alphabet($urandom_range(MIN_RADIX, MAX_SYMBOLS), flaw_t'(f));
			send_value($urandom, 0);
			settle();
		end

		phase = 0;
		while (random_good + random_ignored < RANDOM_TARGET) begin
			flaw = ($urandom_range(0, 5) == 0) ?
				flaw_t'($urandom_range(FLAW_DUP, FLAW_MANY)) : FLAW_NONE;
			if (phase == 0)
				radix = MIN_RADIX;
			else if (phase == 1)
				radix = MAX_SYMBOLS;
			else
				radix = $urandom_range(MIN_RADIX, MAX_SYMBOLS);
			load_alphabet(radix, flaw);
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ((!drained_once && flaw == FLAW_NONE && k == PHASE_ITEMS / 2) ||
				    $urandom_range(0, 99) == 0) begin
					wait_drained();
					drained_once = 1'b1;
				end
				send_value(draw_value(), steady ? 0 : $urandom_range(0, 4));
				if (flaw == FLAW_NONE)
					random_good++;
				else
					random_ignored++;
			end
			settle();
			phase++;
		end

		$display("Sent %0d values across %0d alphabets (%0d under a bad alphabet in the random part).",
			values_sent, alphabets_loaded, random_ignored);
		$display("Checked %0d characters, radix %0d through %0d, sign and extreme values included.",
			checked, MIN_RADIX, MAX_SYMBOLS);
		if (pending != 0)
			$error("%0d expected characters never came out", pending);
		if (error_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
